[sv/sqr_pkg.sv]
package sqr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int POS_W       = 5;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_EMPTY     = 2'd1;
    localparam logic [1:0] RC_FULL      = 2'd2;
    localparam logic [1:0] RC_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [ID_WIDTH-1:0]  request_id;
        logic [KEY_WIDTH-1:0] request_key;
    } request_t;

    typedef struct packed {
        logic [1:0]           result_code;
        logic [POS_W-1:0]     accept_position;
        logic [ID_WIDTH-1:0]  head_id;
        logic [KEY_WIDTH-1:0] head_key;
        logic [POS_W-1:0]     queue_length;
    } result_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]  id;
        logic [KEY_WIDTH-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

[sv/sorted_request_queue_unit.sv]
// Sorted request queue: up to QUEUE_DEPTH entries (id, key) kept in ascending
// key order, head first.
// Request channel: a transaction is taken on a rising edge with start high and
// busy low; request carries opcode, request_id and request_key.
// Opcodes: enqueue (sorted insert, reports 1-based position), dequeue head,
// cancel the first entry from the head whose id matches.
// Result channel: done is high for exactly one cycle with result valid; it
// carries result code, position, removed head id/key and the new length.
// The receiver cannot stall; each transaction yields exactly one result.
// With n entries held: full, empty and no-op cases and enqueue into an empty
// queue finish from the idle state without a walk; enqueue examines one entry
// per cycle from the tail until it finds its slot; dequeue and cancel examine
// all n entries, one per cycle from the head.
// busy stays high until the result is registered, and the next start may be
// taken in the done cycle.
// The walk rate is set by the entry memory's single read port and one shared
// key comparator. Reset empties the queue; entry contents are not cleared.
module sorted_request_queue_unit
    import sqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    mem_req_t mem_req;
    entry_t   rd_data;

    sqr_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    sqr_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

[sv/sqr_store.sv]
module sqr_store
    import sqr_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rd_data
);

    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data_reg <= entry_mem[mem_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sqr_seq.sv]
module sqr_seq
    import sqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result,
    output mem_req_t mem_req,
    input  entry_t   rd_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_ENQ, ST_PUT, ST_REM} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [1:0]           op_reg, op_next;
    logic [ID_WIDTH-1:0]  id_reg, id_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 found_reg, found_next;
    entry_t               head_reg, head_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic             at_end;
    logic             key_lt;
    logic             key_eq;
    logic             shift;
    logic             match;
    entry_t           new_entry;
    logic             fin;
    logic [1:0]       fin_code;
    logic [POS_W-1:0] fin_pos;
    entry_t           fin_head;

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign last_idx  = cnt_m1[IDX_W-1:0];
    assign new_entry = '{id: id_reg, key: key_reg};

    // shared key comparator; equal keys shift only between head and tail
    assign at_end = (ptr_reg == last_idx) || (ptr_reg == '0);
    assign key_lt = key_reg < rd_data.key;
    assign key_eq = key_reg == rd_data.key;
    assign shift  = key_lt || (!at_end && key_eq);
    assign match  = (op_reg == OP_DEQUEUE) || (rd_data.id == id_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        fin         = 1'b0;
        fin_code    = RC_OK;
        fin_pos     = '0;
        fin_head    = '0;
        mem_req     = '0;
        mem_req.rd_addr = ptr_reg;
        mem_req.wr_data = new_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.opcode;
                    id_next    = request.request_id;
                    key_next   = request.request_key;
                    found_next = 1'b0;
                    head_next  = '0;
                    unique case (request.opcode)
                        OP_ENQUEUE:
                        begin
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                fin      = 1'b1;
                                fin_code = RC_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = '0;
                                mem_req.wr_data = '{id: request.request_id,
                                                    key: request.request_key};
                                cnt_next = CNT_W'(1);
                                fin      = 1'b1;
                                fin_pos  = POS_W'(1);
                            end
                            else
                            begin
                                ptr_next        = last_idx;
                                mem_req.rd_addr = last_idx;
                                state_next      = ST_ENQ;
                            end
                        end
                        OP_DEQUEUE, OP_CANCEL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin      = 1'b1;
                                fin_code = (request.opcode == OP_DEQUEUE) ? RC_EMPTY
                                                                          : RC_NOT_FOUND;
                            end
                            else
                            begin
                                ptr_next        = '0;
                                mem_req.rd_addr = '0;
                                state_next      = ST_REM;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_ENQ:
            begin
                // walk down from the tail, moving each larger entry up one slot
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg + IDX_W'(1);
                if (shift)
                begin
                    mem_req.wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ptr_next        = ptr_reg - IDX_W'(1);
                        mem_req.rd_addr = ptr_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    fin      = 1'b1;
                    fin_pos  = POS_W'(ptr_reg) + POS_W'(2);
                end
            end
            ST_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                cnt_next        = cnt_reg + CNT_W'(1);
                fin             = 1'b1;
                fin_pos         = POS_W'(1);
            end
            ST_REM:
            begin
                // walk up from the head; after the removed entry, move each down one slot
                if (found_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ptr_reg - IDX_W'(1);
                    mem_req.wr_data = rd_data;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                    if (op_reg == OP_DEQUEUE)
                    begin
                        head_next = rd_data;
                    end
                end

                if (ptr_reg == last_idx)
                begin
                    fin = 1'b1;
                    if (found_reg || match)
                    begin
                        cnt_next = cnt_m1;
                        fin_head = head_next;
                    end
                    else
                    begin
                        fin_code = RC_NOT_FOUND;
                    end
                end
                else
                begin
                    ptr_next        = ptr_reg + IDX_W'(1);
                    mem_req.rd_addr = ptr_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next                  = ST_IDLE;
            done_next                   = 1'b1;
            result_next.result_code     = fin_code;
            result_next.accept_position = fin_pos;
            result_next.head_id         = fin_head.id;
            result_next.head_key        = fin_head.key;
            result_next.queue_length    = POS_W'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        key_reg    <= key_next;
        head_reg   <= head_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_cnt_moves_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> done_reg)
        else $error("entry count changed without a result");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (CNT_W'(mem_req.wr_addr) <= cnt_reg))
        else $error("write beyond the tail");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.result_code == RC_FULL)
            |-> (cnt_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full reject with room left");
`endif

endmodule
